// ----- rtl/core/ils_pkg.sv -----
// Shared operation codes, status codes and cell command types for the indexed list store.
`default_nettype none
package ils_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned COUNT_W = 7;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// What every cell of the chain does in this cycle.
	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_PUSH   = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_REMOVE = 2'd3
	} act_kind_t;

	typedef struct packed {
		act_kind_t          kind;
		logic [DATA_W-1:0]  data;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/ils_cell.sv -----
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
`default_nettype none
module ils_cell #(
	parameter int unsigned PW  = 7,
	parameter int unsigned POS = 0
) (
	input  wire                              clk,
	input  wire  ils_pkg::cell_cmd_t         cmd,
	input  wire  [PW-1:0]                    pos,
	input  wire  [PW-1:0]                    rd_pos,
	input  wire  [ils_pkg::DATA_W-1:0]       left_data,
	input  wire  [ils_pkg::DATA_W-1:0]       right_data,
	output logic [ils_pkg::DATA_W-1:0]       data,
	output logic [ils_pkg::DATA_W-1:0]       rd_data
);

	localparam logic [PW-1:0] MY_POS = PW'(POS);

	logic [ils_pkg::DATA_W-1:0] data_q;
	logic [ils_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd.kind)
			ils_pkg::ACT_PUSH: begin
				if (MY_POS == pos) data_d = cmd.data;
			end
			ils_pkg::ACT_INSERT: begin
				// Cells past the insertion point take their left neighbor's entry.
				if (MY_POS == pos) data_d = cmd.data;
				else if (MY_POS > pos) data_d = left_data;
			end
			ils_pkg::ACT_REMOVE: begin
				if (MY_POS >= pos) data_d = right_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	assign rd_data = (rd_pos == MY_POS) ? data_q : '0;

endmodule
`default_nettype wire

// ----- rtl/core/ils_ctrl.sv -----
// List control: length register, error checks and the command broadcast to the cells.
`default_nettype none
module ils_ctrl #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned LW    = 7
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              vld,
	input  wire  [ils_pkg::OP_W-1:0]         op,
	input  wire  [ils_pkg::IDX_W-1:0]        idx,
	input  wire  [ils_pkg::DATA_W-1:0]       val,
	output ils_pkg::cell_cmd_t               cmd,
	output logic [LW-1:0]                    pos,
	output logic [LW-1:0]                    rd_pos,
	output logic                             rd_en,
	output logic [ils_pkg::STAT_W-1:0]       status,
	output logic [LW-1:0]                    len_next
);

	localparam int unsigned CW = (LW > ils_pkg::IDX_W) ? LW : ils_pkg::IDX_W;

	logic [LW-1:0] len_q;
	logic          full;
	logic          empty;
	logic          in_range;

	assign full     = (len_q == LW'(DEPTH));
	assign empty    = (len_q == '0);
	assign in_range = (CW'(idx) < CW'(len_q));

	always_comb begin
		cmd.kind = ils_pkg::ACT_NONE;
		cmd.data = val;
		status   = ils_pkg::ST_OK;
		rd_en    = 1'b0;
		len_next = len_q;
		pos      = LW'(idx);
		rd_pos   = LW'(idx);
		case (op)
			ils_pkg::OP_PUSH: begin
				pos = len_q;
				if (full) begin
					status = ils_pkg::ST_FULL;
				end else begin
					cmd.kind = ils_pkg::ACT_PUSH;
					len_next = len_q + 1'b1;
				end
			end
			ils_pkg::OP_POP: begin
				rd_pos = len_q - 1'b1;
				if (empty) begin
					status = ils_pkg::ST_EMPTY;
				end else begin
					rd_en    = 1'b1;
					len_next = len_q - 1'b1;
				end
			end
			ils_pkg::OP_INSERT: begin
				if (full) begin
					status = ils_pkg::ST_FULL;
				end else if (!in_range) begin
					status = ils_pkg::ST_RANGE;
				end else begin
					cmd.kind = ils_pkg::ACT_INSERT;
					len_next = len_q + 1'b1;
				end
			end
			ils_pkg::OP_REMOVE: begin
				if (!in_range) begin
					status = ils_pkg::ST_RANGE;
				end else begin
					cmd.kind = ils_pkg::ACT_REMOVE;
					len_next = len_q - 1'b1;
				end
			end
			ils_pkg::OP_READ: begin
				if (!in_range) status = ils_pkg::ST_RANGE;
				else rd_en = 1'b1;
			end
			default: begin
				status = ils_pkg::ST_OK;
			end
		endcase
		if (!vld) cmd.kind = ils_pkg::ACT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (vld) begin
			len_q <= len_next;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/indexed_list_store.sv -----
// Top level of the indexed list store: command register, cell chain and result register.
//
// An ordered list of up to DEPTH signed 32-bit entries. A command beat (op, index,
// value) is taken at a rising edge where start is high and busy is low. busy is
// always low: the block takes one command every cycle, back to back.
// Ops are push to end, pop from end, insert before index, remove at index and
// read at index. Every command gives exactly one result beat: done is high for one
// cycle with value_out, status and count (entries after the command). The receiver
// cannot stall, so results leave in command order with no buffering.
// The command is registered, then applied to the cell chain while the selected
// entry is read out and registered with the status. Each entry lives in one cell;
// insert and remove move every later cell's entry to its neighbor at once, so the
// rate is one command per cycle.
// Errors (empty, out of range, full) leave the list unchanged and return value 0.
// Reset (arst_n low) empties the list and drops any command in flight; entry
// contents are not cleared since only entries below the count are ever read.
`default_nettype none
module indexed_list_store #(
	parameter int unsigned DEPTH = 64
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	output logic                                    busy,
	input  wire         [ils_pkg::OP_W-1:0]         op,
	input  wire         [ils_pkg::IDX_W-1:0]        index,
	input  wire  signed [ils_pkg::DATA_W-1:0]       value,
	output logic                                    done,
	output logic signed [ils_pkg::DATA_W-1:0]       value_out,
	output logic        [ils_pkg::STAT_W-1:0]       status,
	output logic        [ils_pkg::COUNT_W-1:0]      count
);

	localparam int unsigned LW = $clog2(DEPTH + 1);

	logic                          vld_s1;
	logic [ils_pkg::OP_W-1:0]      op_s1;
	logic [ils_pkg::IDX_W-1:0]     idx_s1;
	logic [ils_pkg::DATA_W-1:0]    value_s1;

	ils_pkg::cell_cmd_t            cmd;
	logic [LW-1:0]                 pos;
	logic [LW-1:0]                 rd_pos;
	logic                          rd_en;
	logic [ils_pkg::STAT_W-1:0]    status_d;
	logic [LW-1:0]                 len_next;

	logic [ils_pkg::DATA_W-1:0]    cell_data [DEPTH];
	logic [ils_pkg::DATA_W-1:0]    cell_rd   [DEPTH];
	logic [ils_pkg::DATA_W-1:0]    rd_or;

	logic                          done_q;
	logic [ils_pkg::DATA_W-1:0]    value_out_q;
	logic [ils_pkg::STAT_W-1:0]    status_q;
	logic [ils_pkg::COUNT_W-1:0]   count_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= op;
			idx_s1   <= index;
			value_s1 <= value;
		end
	end

	ils_ctrl #(
		.DEPTH (DEPTH),
		.LW    (LW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_s1),
		.op       (op_s1),
		.idx      (idx_s1),
		.val      (value_s1),
		.cmd      (cmd),
		.pos      (pos),
		.rd_pos   (rd_pos),
		.rd_en    (rd_en),
		.status   (status_d),
		.len_next (len_next)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ils_pkg::DATA_W-1:0] left_d;
		logic [ils_pkg::DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		// The last cell has no right neighbor; on a remove it simply keeps its entry.
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		ils_cell #(
			.PW  (LW),
			.POS (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (pos),
			.rd_pos     (rd_pos),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// At most one cell matches the read position, so an OR merges the chain's outputs.
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			value_out_q <= rd_en ? rd_or : '0;
			status_q    <= status_d;
			count_q     <= ils_pkg::COUNT_W'(len_next);
		end
	end

	assign done      = done_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign count     = count_q;

endmodule
`default_nettype wire

// ----- rtl/core/ils_checker.sv -----
// Port-level checks for the indexed list store, bound to its top level.
`default_nettype none
module ils_checker #(
	parameter int unsigned DEPTH = 64
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	input  wire                                     busy,
	input  wire                                     done,
	input  wire  signed [ils_pkg::DATA_W-1:0]       value_out,
	input  wire         [ils_pkg::STAT_W-1:0]       status,
	input  wire         [ils_pkg::COUNT_W-1:0]      count
);

	// Every accepted command beat produces its result beat after the command and result registers.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result beat missing after accepted command");

	// A result beat never appears without a command beat before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without a command beat");

	// Failed commands return a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ils_pkg::ST_OK) |-> (value_out == '0))
		else $error("nonzero value on an error result");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ils_pkg::ST_EMPTY) |-> (count == '0))
		else $error("empty status with a nonzero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ils_pkg::ST_FULL) |-> (count == ils_pkg::COUNT_W'(DEPTH)))
		else $error("full status while the list is not full");

endmodule

bind indexed_list_store ils_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);
`default_nettype wire

// ----- verif/tb_indexed_list_store.sv -----
// Self-checking testbench for the indexed list store, with directed and random command beats.
module tb_indexed_list_store;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DATA_W  = ils_pkg::DATA_W;
	localparam int unsigned OP_W    = ils_pkg::OP_W;
	localparam int unsigned IDX_W   = ils_pkg::IDX_W;
	localparam int unsigned STAT_W  = ils_pkg::STAT_W;
	localparam int unsigned COUNT_W = ils_pkg::COUNT_W;

	localparam int unsigned LIST_DEPTH = 64;
	localparam int unsigned TAIL_CYCLES = 10;
	localparam int unsigned MAX_PRINTED = 40;

	// Op codes that the block ignores.
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [STAT_W-1:0]        status;
		logic [COUNT_W-1:0]       count;
	} list_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [OP_W-1:0]             op = '0;
	logic [IDX_W-1:0]            index = '0;
	logic signed [DATA_W-1:0]    value = '0;
	logic                        done;
	logic signed [DATA_W-1:0]    value_out;
	logic [STAT_W-1:0]           status;
	logic [COUNT_W-1:0]          count;

	// Predicted list contents and the results still owed by the block.
	logic signed [DATA_W-1:0]    list_entries [LIST_DEPTH];
	int unsigned                 list_len = 0;
	list_result_t                pending_results [$];

	int unsigned                 mismatch_count = 0;
	int unsigned                 idle_pct = 0;
	int unsigned                 burst_left = 0;

	indexed_list_store #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.index(index),
		.value(value),
		.done(done),
		.value_out(value_out),
		.status(status),
		.count(count)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
	endtask

	// Applies one command to the predicted list and returns the result it must give.
	function automatic list_result_t apply_list_command(input logic [OP_W-1:0] c_op,
			input logic [IDX_W-1:0] c_idx, input logic signed [DATA_W-1:0] c_val);
		list_result_t res;
		res = '0;
		res.status = ils_pkg::ST_OK;
		case (c_op)
			ils_pkg::OP_PUSH: begin
				if (list_len >= LIST_DEPTH) begin
					res.status = ils_pkg::ST_FULL;
				end else begin
					list_entries[list_len] = c_val;
					list_len++;
				end
			end
			ils_pkg::OP_POP: begin
				if (list_len == 0) begin
					res.status = ils_pkg::ST_EMPTY;
				end else begin
					list_len--;
					res.value_out = list_entries[list_len];
				end
			end
			ils_pkg::OP_INSERT: begin
				// A full list is reported before the index is looked at.
				if (list_len >= LIST_DEPTH) begin
					res.status = ils_pkg::ST_FULL;
				end else if (c_idx >= list_len) begin
					res.status = ils_pkg::ST_RANGE;
				end else begin
					for (int i = list_len; i > c_idx; i--) begin
						list_entries[i] = list_entries[i-1];
					end
					list_entries[c_idx] = c_val;
					list_len++;
				end
			end
			ils_pkg::OP_REMOVE: begin
				if (c_idx >= list_len) begin
					res.status = ils_pkg::ST_RANGE;
				end else begin
					for (int i = c_idx; i + 1 < list_len; i++) begin
						list_entries[i] = list_entries[i+1];
					end
					list_len--;
				end
			end
			ils_pkg::OP_READ: begin
				if (c_idx >= list_len) begin
					res.status = ils_pkg::ST_RANGE;
				end else begin
					res.value_out = list_entries[c_idx];
				end
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(list_len);
		return res;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(15))
			0: return VALUE_MIN;
			1: return VALUE_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Drives one command beat, idling first as the current phase asks, and
	// records the expected result at the accepting edge.
	task automatic send_command(input logic [OP_W-1:0] c_op, input logic [IDX_W-1:0] c_idx,
			input logic signed [DATA_W-1:0] c_val);
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(15) == 0) begin
			burst_left = $urandom_range(4, 16);
		end
		while (burst_left == 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			op <= OP_W'($urandom);
			index <= IDX_W'($urandom);
			value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= c_op;
		index <= c_idx;
		value <= c_val;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		pending_results.push_back(apply_list_command(c_op, c_idx, c_val));
	endtask

	// Stops sending and waits until every outstanding result beat has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_list();
		idle_pct = 0;
		send_command(ils_pkg::OP_POP, '0, random_value());
		send_command(ils_pkg::OP_READ, '0, random_value());
		send_command(ils_pkg::OP_REMOVE, '0, random_value());
		send_command(ils_pkg::OP_INSERT, '0, random_value());
		send_command(ils_pkg::OP_READ, IDX_W'(LIST_DEPTH - 1), random_value());
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
			send_command(OP_W'(c), IDX_W'($urandom), random_value());
		end
	endtask

	task automatic test_edit_ops();
		idle_pct = 0;
		send_command(ils_pkg::OP_PUSH, '0, VALUE_MAX);
		send_command(ils_pkg::OP_PUSH, '0, VALUE_MIN);
		send_command(ils_pkg::OP_PUSH, '0, '0);
		send_command(ils_pkg::OP_PUSH, '0, '1);
		send_command(ils_pkg::OP_INSERT, '0, random_value());
		send_command(ils_pkg::OP_INSERT, IDX_W'(3), random_value());
		send_command(ils_pkg::OP_READ, '0, random_value());
		send_command(ils_pkg::OP_READ, IDX_W'(list_len - 1), random_value());
		send_command(ils_pkg::OP_READ, IDX_W'(list_len), random_value());
		send_command(ils_pkg::OP_READ, IDX_W'(LIST_DEPTH - 1), random_value());
		send_command(ils_pkg::OP_REMOVE, '0, random_value());
		send_command(ils_pkg::OP_REMOVE, IDX_W'(list_len - 1), random_value());
		send_command(ils_pkg::OP_REMOVE, IDX_W'(list_len), random_value());
		// Insert at the count is out of range: it cannot append.
		send_command(ils_pkg::OP_INSERT, IDX_W'(list_len), random_value());
		send_command(ils_pkg::OP_POP, '0, random_value());
	endtask

	task automatic test_fill_to_full();
		idle_pct = 36;
		while (list_len < LIST_DEPTH) begin
			send_command(ils_pkg::OP_PUSH, IDX_W'($urandom), random_value());
		end
		send_command(ils_pkg::OP_PUSH, IDX_W'($urandom), random_value());
		send_command(ils_pkg::OP_INSERT, '0, random_value());
		send_command(ils_pkg::OP_INSERT, IDX_W'(LIST_DEPTH - 1), random_value());
		send_command(ils_pkg::OP_READ, IDX_W'(LIST_DEPTH - 1), random_value());
		send_command(ils_pkg::OP_READ, '0, random_value());
		send_command(ils_pkg::OP_REMOVE, IDX_W'(LIST_DEPTH - 1), random_value());
		send_command(ils_pkg::OP_INSERT, IDX_W'(LIST_DEPTH - 2), random_value());
		send_command(ils_pkg::OP_INSERT, '0, random_value());
		drain_results();
		while (list_len > 0) begin
			if ($urandom_range(1) == 0) begin
				send_command(ils_pkg::OP_POP, IDX_W'($urandom), random_value());
			end else begin
				send_command(ils_pkg::OP_REMOVE, IDX_W'($urandom_range(list_len - 1)),
					random_value());
			end
		end
		send_command(ils_pkg::OP_POP, IDX_W'($urandom), random_value());
		drain_results();
	endtask

	// Random commands steered toward a fill level that changes now and then, so the
	// list spends time empty, full and in between.
	task automatic test_random_mix(input int unsigned idle, input int unsigned beats);
		int unsigned fill_target;
		int unsigned r;
		bit grow;
		logic [OP_W-1:0] c_op;
		logic [IDX_W-1:0] c_idx;
		idle_pct = idle;
		fill_target = 0;
		for (int n = 0; n < beats; n++) begin
			if (n % 40 == 0) begin
				r = $urandom_range(99);
				fill_target = (r < 25) ? LIST_DEPTH :
					(r < 40) ? 0 : $urandom_range(1, LIST_DEPTH - 1);
			end
			grow = list_len < fill_target;
			r = $urandom_range(99);
			if (r < 5) begin
				c_op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			end else if (r < (grow ? 40 : 13)) begin
				c_op = ils_pkg::OP_PUSH;
			end else if (r < (grow ? 65 : 23)) begin
				c_op = ils_pkg::OP_INSERT;
			end else if (r < (grow ? 73 : 53)) begin
				c_op = ils_pkg::OP_POP;
			end else if (r < 83) begin
				c_op = ils_pkg::OP_REMOVE;
			end else begin
				c_op = ils_pkg::OP_READ;
			end
			if (list_len > 0 && $urandom_range(99) < 85) begin
				c_idx = IDX_W'($urandom_range(list_len - 1));
			end else begin
				c_idx = IDX_W'($urandom);
			end
			send_command(c_op, c_idx, random_value());
		end
		drain_results();
	endtask

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected result beat value_out=%0d status=%0d count=%0d",
					value_out, status, count));
			end else begin
				want = pending_results.pop_front();
				if (value_out !== want.value_out) begin
					report_mismatch($sformatf("value_out %0d, expected %0d", value_out,
						want.value_out));
				end
				if (status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				end
				if (count !== want.count) begin
					report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_list();
		test_edit_ops();
		test_fill_to_full();
		test_random_mix(0, 140);
		test_random_mix(77, 140);
		test_random_mix(0, 140);
		test_random_mix(36, 140);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ils_pkg.sv
rtl/core/ils_cell.sv
rtl/core/ils_ctrl.sv
rtl/core/indexed_list_store.sv
rtl/core/ils_checker.sv
verif/tb_indexed_list_store.sv
